@@ design/wmap_pkg.sv @@
package wmap_pkg;

	// field and register widths
	localparam int POS_W  = 32;
	localparam int DIM_W  = 16;
	localparam int ROT_W  = 2;
	localparam int APB_DW = 32;
	localparam int APB_AW = 5;

	// per-item divider: signed 32 x unsigned 16 product magnitude fits 48 bits
	localparam int DIV_W              = 48;
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES         = DIV_W / DIV_BITS_PER_STAGE;

	// setup divider: unsigned 16 x 16 product
	localparam int SETUP_W   = 2 * DIM_W;
	localparam int SETUP_CNT = $clog2(SETUP_W);

	// accept edge to result strobe, in cycles
	localparam int PIPE_LAT = 2 * DIV_STAGES + 6;

	// register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_FRAME_W  = 3'd0,
		REG_FRAME_H  = 3'd1,
		REG_ROT      = 3'd2,
		REG_WIN_W    = 3'd3,
		REG_WIN_H    = 3'd4,
		REG_DRAW_W   = 3'd5,
		REG_DRAW_H   = 3'd6
	} reg_idx_t;

	// setup sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWAP,
		ST_MUL,
		ST_DIV1,
		ST_DIV2,
		ST_FIN
	} setup_state_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] frame_x;
		logic signed [POS_W-1:0] frame_y;
		logic                    divide_fault;
	} result_t;

	// static geometry handed from the config block to the datapath
	typedef struct packed {
		logic [DIM_W-1:0] dw;
		logic [DIM_W-1:0] dh;
		logic [DIM_W-1:0] ww;
		logic [DIM_W-1:0] wh;
		logic [DIM_W-1:0] cw;
		logic [DIM_W-1:0] ch;
		logic [DIM_W-1:0] rx;
		logic [DIM_W-1:0] ry;
		logic [DIM_W-1:0] rw;
		logic [DIM_W-1:0] rh;
		logic [ROT_W-1:0] rot;
		logic             fault;
	} geom_t;

endpackage

@@ design/wmap_div.sv @@
module wmap_div import wmap_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic [DIV_W-1:0]    in_mag,
	input  logic                in_neg,
	input  logic [DIM_W-1:0]    divisor,
	output logic                out_vld,
	output logic [POS_W-1:0]    out_q,
	output logic                out_neg
);

	// stage 0 is the input, stage k is after k register stages
	logic               vld_s [DIV_STAGES+1];
	logic               neg_s [DIV_STAGES+1];
	logic [DIM_W-1:0]   rem_s [DIV_STAGES+1];
	logic [DIV_W-1:0]   dq_s  [DIV_STAGES+1];

	assign vld_s[0] = in_vld;
	assign neg_s[0] = in_neg;
	assign rem_s[0] = '0;
	assign dq_s[0]  = in_mag;

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DIM_W-1:0] rem_nx;
		logic [DIV_W-1:0] dq_nx;

		// restoring division, a few quotient bits per stage
		always_comb begin
			logic [DIM_W-1:0] r;
			logic [DIV_W-1:0] d;
			logic [DIM_W:0]   t;
			r = rem_s[g];
			d = dq_s[g];
			for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
				t = {r, d[DIV_W-1]};
				d = {d[DIV_W-2:0], 1'b0};
				if (t >= {1'b0, divisor}) begin
					t    = t - {1'b0, divisor};
					d[0] = 1'b1;
				end
				r = t[DIM_W-1:0];
			end
			rem_nx = r;
			dq_nx  = d;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[g+1] <= neg_s[g];
			rem_s[g+1] <= rem_nx;
			dq_s[g+1]  <= dq_nx;
		end
	end

	assign out_vld = vld_s[DIV_STAGES];
	assign out_neg = neg_s[DIV_STAGES];
	assign out_q   = dq_s[DIV_STAGES][POS_W-1:0];

endmodule

@@ design/wmap_axis.sv @@
module wmap_axis import wmap_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	input  logic signed [POS_W-1:0] pos,
	input  logic [DIM_W-1:0]        snum,
	input  logic [DIM_W-1:0]        sden,
	input  logic [DIM_W-1:0]        off,
	input  logic [DIM_W-1:0]        cnum,
	input  logic [DIM_W-1:0]        cden,
	output logic                    out_vld,
	output logic [POS_W-1:0]        out_q,
	output logic                    out_neg
);

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [DIV_W:0] prod_s1, prod_s4;
	logic [DIV_W-1:0]      mag_s2, mag_s5;
	logic                  neg_s2, neg_s5;
	logic [POS_W-1:0]      xo_s3;
	logic                  d1_vld, d1_neg;
	logic [POS_W-1:0]      d1_q, d1_val;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= d1_vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// scale product, then magnitude for the unsigned divider
	always_ff @(posedge clk) begin
		prod_s1 <= pos * $signed({1'b0, snum});
		neg_s2  <= prod_s1[DIV_W];
		mag_s2  <= DIV_W'(prod_s1[DIV_W] ? -prod_s1 : prod_s1);
	end

	wmap_div u_div_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s2),
		.in_mag  (mag_s2),
		.in_neg  (neg_s2),
		.divisor (sden),
		.out_vld (d1_vld),
		.out_q   (d1_q),
		.out_neg (d1_neg)
	);

	// signed quotient minus letterbox offset, then content product
	assign d1_val = d1_neg ? (POS_W'(0) - d1_q) : d1_q;

	always_ff @(posedge clk) begin
		xo_s3   <= d1_val - {{(POS_W-DIM_W){1'b0}}, off};
		prod_s4 <= $signed(xo_s3) * $signed({1'b0, cnum});
		neg_s5  <= prod_s4[DIV_W];
		mag_s5  <= DIV_W'(prod_s4[DIV_W] ? -prod_s4 : prod_s4);
	end

	wmap_div u_div_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (vld_s5),
		.in_mag  (mag_s5),
		.in_neg  (neg_s5),
		.divisor (cden),
		.out_vld (out_vld),
		.out_q   (out_q),
		.out_neg (out_neg)
	);

endmodule

@@ design/wmap_cfg.sv @@
module wmap_cfg import wmap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              busy,
	output geom_t             geom
);

	logic [DIM_W-1:0] frame_w_q, frame_h_q, win_w_q, win_h_q, draw_w_q, draw_h_q;
	logic [ROT_W-1:0] rot_q;
	logic             wr;
	reg_idx_t         idx;

	setup_state_t       state_q, state_nx;
	logic [DIM_W-1:0]   cw_q, ch_q, rx_q, ry_q, rw_q, rh_q;
	logic               fault_q;
	logic [SETUP_W-1:0] num1_q, num2_q, q1_q, q2_q, dq_q, dq_nx;
	logic [DIM_W-1:0]   rem_q, rem_nx, div_d;
	logic [SETUP_CNT-1:0] cnt_q;
	logic               div_last;
	logic [DIM_W:0]     trial;
	logic [DIM_W-1:0]   rx_nx, ry_nx, rw_nx, rh_nx;
	logic               fault_nx, match, wide;

	assign wr  = psel & penable & pwrite;
	assign idx = reg_idx_t'(paddr[APB_AW-1:2]);

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q <= '0;
			frame_h_q <= '0;
			rot_q     <= '0;
			win_w_q   <= '0;
			win_h_q   <= '0;
			draw_w_q  <= '0;
			draw_h_q  <= '0;
		end else if (wr) begin
			unique case (idx)
				REG_FRAME_W: frame_w_q <= pwdata[DIM_W-1:0];
				REG_FRAME_H: frame_h_q <= pwdata[DIM_W-1:0];
				REG_ROT:     rot_q     <= pwdata[ROT_W-1:0];
				REG_WIN_W:   win_w_q   <= pwdata[DIM_W-1:0];
				REG_WIN_H:   win_h_q   <= pwdata[DIM_W-1:0];
				REG_DRAW_W:  draw_w_q  <= pwdata[DIM_W-1:0];
				REG_DRAW_H:  draw_h_q  <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_FRAME_W: prdata = APB_DW'(frame_w_q);
			REG_FRAME_H: prdata = APB_DW'(frame_h_q);
			REG_ROT:     prdata = APB_DW'(rot_q);
			REG_WIN_W:   prdata = APB_DW'(win_w_q);
			REG_WIN_H:   prdata = APB_DW'(win_h_q);
			REG_DRAW_W:  prdata = APB_DW'(draw_w_q);
			REG_DRAW_H:  prdata = APB_DW'(draw_h_q);
			default:     prdata = '0;
		endcase
	end

	// setup sequencer: next state
	always_comb begin
		state_nx = state_q;
		if (wr) begin
			state_nx = ST_SWAP;
		end else begin
			unique case (state_q)
				ST_IDLE: state_nx = ST_IDLE;
				ST_SWAP: state_nx = ST_MUL;
				ST_MUL:  state_nx = ST_DIV1;
				ST_DIV1: if (div_last) state_nx = ST_DIV2;
				ST_DIV2: if (div_last) state_nx = ST_FIN;
				ST_FIN:  state_nx = ST_IDLE;
				default: state_nx = ST_IDLE;
			endcase
		end
	end

	// setup sequencer: outputs
	always_comb begin
		busy     = (state_q != ST_IDLE);
		div_last = (cnt_q == '1);
		div_d    = (state_q == ST_DIV2) ? ch_q : cw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWAP;
		end else begin
			state_q <= state_nx;
		end
	end

	// one quotient bit per cycle
	always_comb begin
		trial  = {rem_q, dq_q[SETUP_W-1]};
		dq_nx  = {dq_q[SETUP_W-2:0], 1'b0};
		rem_nx = trial[DIM_W-1:0];
		if (trial >= {1'b0, div_d}) begin
			rem_nx   = DIM_W'(trial - {1'b0, div_d});
			dq_nx[0] = 1'b1;
		end
	end

	// letterbox rectangle from the two quotients
	always_comb begin
		match = ({{DIM_W{1'b0}}, draw_h_q} == q1_q) || ({{DIM_W{1'b0}}, draw_w_q} == q2_q);
		wide  = num2_q > num1_q;
		rx_nx = '0;
		ry_nx = '0;
		rw_nx = draw_w_q;
		rh_nx = draw_h_q;
		if (!match) begin
			if (wide) begin
				rh_nx = q1_q[DIM_W-1:0];
				ry_nx = DIM_W'(draw_h_q - rh_nx) >> 1;
			end else begin
				rw_nx = q2_q[DIM_W-1:0];
				rx_nx = DIM_W'(draw_w_q - rw_nx) >> 1;
			end
		end
		fault_nx = (win_w_q == '0) || (win_h_q == '0) || (cw_q == '0) || (ch_q == '0)
			|| (rw_nx == '0) || (rh_nx == '0);
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_SWAP: begin
				cw_q <= rot_q[0] ? frame_h_q : frame_w_q;
				ch_q <= rot_q[0] ? frame_w_q : frame_h_q;
			end
			ST_MUL: begin
				num1_q <= draw_w_q * ch_q;
				num2_q <= draw_h_q * cw_q;
				dq_q   <= draw_w_q * ch_q;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			ST_DIV1: begin
				cnt_q <= cnt_q + 1'b1;
				if (div_last) begin
					q1_q  <= dq_nx;
					dq_q  <= num2_q;
					rem_q <= '0;
				end else begin
					dq_q  <= dq_nx;
					rem_q <= rem_nx;
				end
			end
			ST_DIV2: begin
				cnt_q <= cnt_q + 1'b1;
				dq_q  <= dq_nx;
				rem_q <= rem_nx;
				if (div_last) q2_q <= dq_nx;
			end
			ST_FIN: begin
				rx_q    <= rx_nx;
				ry_q    <= ry_nx;
				rw_q    <= rw_nx;
				rh_q    <= rh_nx;
				fault_q <= fault_nx;
			end
			default: ;
		endcase
	end

	assign geom = '{
		dw: draw_w_q, dh: draw_h_q, ww: win_w_q, wh: win_h_q,
		cw: cw_q, ch: ch_q, rx: rx_q, ry: ry_q, rw: rw_q, rh: rh_q,
		rot: rot_q, fault: fault_q
	};

endmodule

@@ design/window_to_frame_coord_mapper.sv @@
// Window-to-frame pointer coordinate mapper.
// Input channel: drive item (pos_x, pos_y) with start; a transaction is taken at
// a rising edge with start high and busy low. One item may enter every cycle
// while busy is low. Output channel: each transaction yields one result,
// shown for exactly one cycle with done high. The path runs through the two
// 12-stage pipelined dividers per axis (scale and content mapping, 4 quotient
// bits per stage) plus product, magnitude, offset and output stages.
// Sustained rate: one item per cycle while busy is low.
// The receiver cannot stall: results are never held back.
// Configuration: APB registers at byte address 4*index (frame w/h, rotation,
// window w/h, drawable w/h). Every write restarts a setup sequencer that works
// out the letterbox rectangle with a bit-serial divider; busy stays high after
// the write completes until the sequencer is idle again. Write only when no
// transaction is in flight.
// Reset clears the registers to zero, empties the pipeline and runs the same
// setup pass; divide_fault is then reported until sizes are set.
module window_to_frame_coord_mapper import wmap_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  item_t             item,
	output logic              done,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	geom_t            geom;
	logic             acc;
	logic             vx_vld, vy_vld, vx_neg, vy_neg;
	logic [POS_W-1:0] vx_q, vy_q, vx, vy, fx, fy;
	logic             done_q;
	result_t          result_q;

	assign pready = 1'b1;
	assign acc    = start & ~busy;

	wmap_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.busy    (busy),
		.geom    (geom)
	);

	wmap_axis u_axis_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (acc),
		.pos     (item.pos_x),
		.snum    (geom.dw),
		.sden    (geom.ww),
		.off     (geom.rx),
		.cnum    (geom.cw),
		.cden    (geom.rw),
		.out_vld (vx_vld),
		.out_q   (vx_q),
		.out_neg (vx_neg)
	);

	wmap_axis u_axis_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (acc),
		.pos     (item.pos_y),
		.snum    (geom.dh),
		.sden    (geom.wh),
		.off     (geom.ry),
		.cnum    (geom.ch),
		.cden    (geom.rh),
		.out_vld (vy_vld),
		.out_q   (vy_q),
		.out_neg (vy_neg)
	);

	// signed content coordinates, then rotation
	always_comb begin
		vx = vx_neg ? (POS_W'(0) - vx_q) : vx_q;
		vy = vy_neg ? (POS_W'(0) - vy_q) : vy_q;
		unique case (geom.rot)
			2'd0: begin
				fx = vx;
				fy = vy;
			end
			2'd1: begin
				fx = POS_W'(geom.ch) - vy;
				fy = vx;
			end
			2'd2: begin
				fx = POS_W'(geom.cw) - vx;
				fy = POS_W'(geom.ch) - vy;
			end
			default: begin
				fx = vy;
				fy = POS_W'(geom.cw) - vx;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vx_vld & vy_vld;
		end
	end

	always_ff @(posedge clk) begin
		result_q.frame_x      <= geom.fault ? '0 : fx;
		result_q.frame_y      <= geom.fault ? '0 : fy;
		result_q.divide_fault <= geom.fault;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ design/wmap_chk.sv @@
module wmap_chk import wmap_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result,
	input logic    psel,
	input logic    penable,
	input logic    pwrite
);

	// every accepted transaction gives a result after the fixed latency
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("missing result after accepted transaction");

	// no result without a transaction accepted earlier
	a_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without matching transaction");

	// a faulted result carries zero coordinates
	a_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.divide_fault) |-> (result.frame_x == 0 && result.frame_y == 0))
		else $error("fault result with nonzero coordinates");

	// a register write blocks new transactions while geometry is recomputed
	a_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(psel && penable && pwrite) |=> busy)
		else $error("not busy after register write");

endmodule

bind window_to_frame_coord_mapper wmap_chk u_chk (.*);

@@ bench/window_to_frame_coord_mapper_test.sv @@
`timescale 1ns / 100ps

module window_to_frame_coord_mapper_test;
	import wmap_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	item_t             item;
	logic              done;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// shadow copy of the register file, indexed by reg_idx_t
	logic [DIM_W-1:0] geom_regs [7];
	result_t          pending_coords [$];
	int               mismatch_cnt;

	// directed rows: expected values typed in where chk is set
	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		bit          chk;
		logic [31:0] ex;
		logic [31:0] ey;
		logic        ef;
	} dir_row_t;

	localparam int N_RESET_ROWS = 4;
	localparam int N_DIR_ROWS   = 14;
	dir_row_t dir_rows [N_DIR_ROWS] = '{
		// reset geometry: all sizes zero, always a fault
		'{32'd0,        32'd0,        1'b1, 32'd0,    32'd0,    1'b1},
		'{32'h7fffffff, 32'h7fffffff, 1'b1, 32'd0,    32'd0,    1'b1},
		'{32'h80000000, 32'h80000000, 1'b1, 32'd0,    32'd0,    1'b1},
		'{32'hffffffff, 32'd5,        1'b1, 32'd0,    32'd0,    1'b1},
		// 1920x1080 everywhere, rotation 0: identity
		'{32'd0,        32'd0,        1'b1, 32'd0,    32'd0,    1'b0},
		'{32'd100,      32'd200,      1'b1, 32'd100,  32'd200,  1'b0},
		'{32'd1919,     32'd1079,     1'b1, 32'd1919, 32'd1079, 1'b0},
		'{32'hffffffff, 32'hfffffffe, 1'b1, 32'hffffffff, 32'hfffffffe, 1'b0},
		// these rows go through the predictor: extremes and other points
		'{32'h7fffffff, 32'h7fffffff, 1'b0, 32'd0,    32'd0,    1'b0},
		'{32'h80000000, 32'h80000000, 1'b0, 32'd0,    32'd0,    1'b0},
		'{32'h80000000, 32'h7fffffff, 1'b0, 32'd0,    32'd0,    1'b0},
		'{32'h55555555, 32'haaaaaaaa, 1'b0, 32'd0,    32'd0,    1'b0},
		'{32'd960,      32'd540,      1'b0, 32'd0,    32'd0,    1'b0},
		'{32'hfff00000, 32'h000fffff, 1'b0, 32'd0,    32'd0,    1'b0}
	};

	window_to_frame_coord_mapper dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// letterbox fit, HiDPI scale, content mapping and rotation
	function automatic result_t map_point(item_t it);
		longint unsigned cw, ch, dw, dh, ww, wh, rx, ry, rw, rh;
		longint          prod;
		logic [31:0]     x, y;
		logic [1:0]      rot;
		result_t         r;
		rot = geom_regs[REG_ROT][1:0];
		dw  = geom_regs[REG_DRAW_W];
		dh  = geom_regs[REG_DRAW_H];
		ww  = geom_regs[REG_WIN_W];
		wh  = geom_regs[REG_WIN_H];
		cw  = rot[0] ? geom_regs[REG_FRAME_H] : geom_regs[REG_FRAME_W];
		ch  = rot[0] ? geom_regs[REG_FRAME_W] : geom_regs[REG_FRAME_H];
		rx  = 0;
		ry  = 0;
		rw  = 0;
		rh  = 0;
		r   = '0;
		r.divide_fault = (ww == 0) || (wh == 0) || (cw == 0) || (ch == 0);
		if (!r.divide_fault) begin
			if (dh == dw * ch / cw || dw == dh * cw / ch) begin
				rw = dw;
				rh = dh;
			end else if (cw * dh > ch * dw) begin
				// wide content: full width, height centered
				rw = dw;
				rh = dw * ch / cw;
				ry = (dh - rh) / 2;
			end else begin
				rh = dh;
				rw = dh * cw / ch;
				rx = (dw - rw) / 2;
			end
			if (rw == 0 || rh == 0)
				r.divide_fault = 1'b1;
		end
		if (!r.divide_fault) begin
			prod = longint'(it.pos_x) * longint'(dw) / longint'(ww);
			x = prod[31:0] - rx[31:0];
			prod = longint'(it.pos_y) * longint'(dh) / longint'(wh);
			y = prod[31:0] - ry[31:0];
			prod = longint'($signed(x)) * longint'(cw) / longint'(rw);
			x = prod[31:0];
			prod = longint'($signed(y)) * longint'(ch) / longint'(rh);
			y = prod[31:0];
			case (rot)
				2'd0: begin
					r.frame_x = x;
					r.frame_y = y;
				end
				2'd1: begin
					r.frame_x = ch[31:0] - y;
					r.frame_y = x;
				end
				2'd2: begin
					r.frame_x = cw[31:0] - x;
					r.frame_y = ch[31:0] - y;
				end
				default: begin
					r.frame_x = y;
					r.frame_y = cw[31:0] - x;
				end
			endcase
		end
		return r;
	endfunction

	// APB write; called at a falling edge, returns at a falling edge
	task automatic apb_write(reg_idx_t idx, logic [15:0] val);
		logic [31:0] wdata;
		wdata = {16'($urandom_range(0, 16'hffff)), val};
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'(idx) << 2;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'($urandom_range(0, 1));
		geom_regs[idx] = val;
	endtask

	// wait for the pipeline to drain, then rewrite every register
	task automatic load_geometry(logic [15:0] fw, logic [15:0] fh, logic [1:0] rot,
			logic [15:0] ww, logic [15:0] wh, logic [15:0] dw, logic [15:0] dh);
		start <= 1'b0;
		while (pending_coords.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT) @(negedge clk);
		apb_write(REG_FRAME_W, fw);
		apb_write(REG_FRAME_H, fh);
		apb_write(REG_ROT, {14'd0, rot});
		apb_write(REG_WIN_W, ww);
		apb_write(REG_WIN_H, wh);
		apb_write(REG_DRAW_W, dw);
		apb_write(REG_DRAW_H, dh);
	endtask

	// send one transaction; the expectation is queued at the accepting edge
	task automatic send_point(item_t it, bit typed, result_t typed_res);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		pending_coords.push_back(typed ? typed_res : map_point(it));
		@(negedge clk);
	endtask

	function automatic logic [15:0] pick_dim();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'hffff;
			2, 3:    return 16'($urandom_range(1, 8));
			4, 5:    return 16'($urandom_range(1, 4096));
			default: return 16'($urandom_range(1, 16'hffff));
		endcase
	endfunction

	function automatic logic [31:0] pick_pos(logic [15:0] lim);
		case ($urandom_range(0, 7))
			0:       return $urandom();
			1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			2:       return -32'($urandom_range(0, 64));
			default: return 32'($urandom_range(0, int'(lim) + 2));
		endcase
	endfunction

	// result checker
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_coords.size() == 0) begin
				$error("result with no transaction pending: x=%0d y=%0d fault=%0b",
					result.frame_x, result.frame_y, result.divide_fault);
				mismatch_cnt++;
			end else begin
				want = pending_coords.pop_front();
				if (result.frame_x !== want.frame_x) begin
					$error("frame_x expected %0d got %0d", want.frame_x, result.frame_x);
					mismatch_cnt++;
				end
				if (result.frame_y !== want.frame_y) begin
					$error("frame_y expected %0d got %0d", want.frame_y, result.frame_y);
					mismatch_cnt++;
				end
				if (result.divide_fault !== want.divide_fault) begin
					$error("divide_fault expected %0b got %0b", want.divide_fault,
						result.divide_fault);
					mismatch_cnt++;
				end
			end
		end
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// stimulus
	initial begin
		item_t       it;
		result_t     tr;
		logic [15:0] fw, fh, ww, wh, dw, dh;
		int          n;
		mismatch_cnt = 0;
		for (int i = 0; i < 7; i++)
			geom_regs[i] = '0;
		arst_n  = 1'b0;
		start   = 1'b0;
		item    = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// directed table
		for (int i = 0; i < N_DIR_ROWS; i++) begin
			if (i == N_RESET_ROWS)
				load_geometry(16'd1920, 16'd1080, 2'd0, 16'd1920, 16'd1080,
					16'd1920, 16'd1080);
			it.pos_x = dir_rows[i].px;
			it.pos_y = dir_rows[i].py;
			tr.frame_x = dir_rows[i].ex;
			tr.frame_y = dir_rows[i].ey;
			tr.divide_fault = dir_rows[i].ef;
			send_point(it, dir_rows[i].chk, tr);
		end

		// directed geometries: wide, tall, HiDPI, every rotation, extremes
		for (int g = 0; g < 6; g++) begin
			case (g)
				0: load_geometry(16'd1920, 16'd1080, 2'd1, 16'd800, 16'd600,
					16'd1600, 16'd1200);
				1: load_geometry(16'd1080, 16'd1920, 2'd2, 16'd1000, 16'd500,
					16'd2000, 16'd1000);
				2: load_geometry(16'd640, 16'd480, 2'd3, 16'd1280, 16'd400,
					16'd1280, 16'd400);
				3: load_geometry(16'hffff, 16'hffff, 2'd3, 16'hffff, 16'hffff,
					16'hffff, 16'hffff);
				4: load_geometry(16'hffff, 16'd1, 2'd0, 16'd1, 16'd1,
					16'hffff, 16'hffff);
				default: load_geometry(16'd3, 16'd7, 2'd1, 16'd1, 16'hffff,
					16'd1, 16'd0);
			endcase
			for (int k = 0; k < 6; k++) begin
				it.pos_x = pick_pos(16'd2000);
				it.pos_y = pick_pos(16'd2000);
				send_point(it, 1'b0, tr);
			end
		end

		// random geometries, mostly valid
		n = 0;
		while (n < 780) begin
			fw = pick_dim();
			fh = pick_dim();
			ww = pick_dim();
			wh = pick_dim();
			dw = pick_dim();
			dh = pick_dim();
			if ($urandom_range(0, 3) != 0) begin
				if (fw == 0) fw = 16'd1;
				if (fh == 0) fh = 16'd1;
				if (ww == 0) ww = 16'd1;
				if (wh == 0) wh = 16'd1;
			end
			load_geometry(fw, fh, 2'($urandom_range(0, 3)), ww, wh, dw, dh);
			for (int k = 0; k < 60; k++) begin
				it.pos_x = pick_pos(ww);
				it.pos_y = pick_pos(wh);
				send_point(it, 1'b0, tr);
				n++;
			end
		end

		// drain
		start <= 1'b0;
		while (pending_coords.size() != 0)
			@(negedge clk);
		repeat (PIPE_LAT + 8) @(negedge clk);
		if (mismatch_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
